/* rtl/tmpg_pkg.sv */
// Shared types and constants for the text-mode pixel generator.
// Used by tmpg_front, tmpg_back and the top module. Depends on nothing.
`default_nettype none

package tmpg_pkg;

  // Default geometry, handed down as top-level parameters
  localparam int LINE_STRIDE      = 100;
  localparam int SCREEN_COLUMNS   = 96;
  localparam int SCREEN_ROWS      = 71;
  localparam int TEXT_STORE_DEPTH = 8192;

  // Fixed store sizes
  localparam int FONT_DEPTH    = 2048;
  localparam int FONT_AW       = $clog2(FONT_DEPTH);
  localparam int PALETTE_DEPTH = 32;
  localparam int PALETTE_AW    = $clog2(PALETTE_DEPTH);
  // Text offset width that covers the largest allowed text store
  localparam int TEXT_AW_MAX   = 14;

  // Queue between front and back, and result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_DEPTH   = 8;
  localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

  localparam int COLOUR_W = 12;

  typedef enum logic [2:0] {
    CMD_PIXEL      = 3'd0,
    CMD_WR_CHAR    = 3'd1,
    CMD_WR_ATTR    = 3'd2,
    CMD_WR_FONT    = 3'd3,
    CMD_WR_PALETTE = 3'd4,
    CMD_FRAME      = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    REG_CURSOR_ENABLE    = 3'd0,
    REG_CURSOR_ROW       = 3'd1,
    REG_CURSOR_COLUMN    = 3'd2,
    REG_CURSOR_GLYPH     = 3'd3,
    REG_CURSOR_ATTRIBUTE = 3'd4
  } reg_t;

  typedef struct packed {
    logic        cursor_enable;
    logic [15:0] cursor_row;
    logic [15:0] cursor_column;
    logic [7:0]  cursor_glyph;
    logic [7:0]  cursor_attribute;
  } cfg_t;

  // One classified transaction on its way from front to back
  typedef struct packed {
    cmd_t                    op;
    logic [TEXT_AW_MAX-1:0]  addr;
    logic [COLOUR_W-1:0]     wdata;
    logic [2:0]              line;
    logic [2:0]              bitsel;
    logic                    outside;
    logic                    cursor;
  } q_entry_t;

  localparam int Q_ENTRY_W = $bits(q_entry_t);

endpackage

`default_nettype wire

/* rtl/tmpg_ram.sv */
// Generic single-port RAM with registered read data.
// Used for every store of the pixel generator. No dependencies.
`default_nettype none

module tmpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/tmpg_fifo.sv */
// Small flip-flop FIFO with occupancy count (power-of-two depth).
// Used as the front/back queue and the result queue. No dependencies.
`default_nettype none

module tmpg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           push_data,
  input  wire logic                       pop,
  output logic                            valid,
  output logic      [WIDTH-1:0]           pop_data,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_pop;

  assign do_pop = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push);
    rd_ptr_nxt = rd_ptr_r + PW'(do_pop);
    count_nxt  = count_r + CW'(push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign valid    = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign count    = count_r;

endmodule

`default_nettype wire

/* rtl/tmpg_front.sv */
// Front end: accepts input transactions, tracks the blink counter, classifies
// commands and computes the text cell offset. Depends on tmpg_pkg.
`default_nettype none

module tmpg_front #(
  parameter int LINE_STRIDE      = tmpg_pkg::LINE_STRIDE,
  parameter int SCREEN_COLUMNS   = tmpg_pkg::SCREEN_COLUMNS,
  parameter int SCREEN_ROWS      = tmpg_pkg::SCREEN_ROWS,
  parameter int TEXT_STORE_DEPTH = tmpg_pkg::TEXT_STORE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [2:0]                      in_command,
  input  wire logic [12:0]                     in_address,
  input  wire logic [31:0]                     in_write_data,
  input  wire logic [9:0]                      in_pixel_x,
  input  wire logic [9:0]                      in_pixel_y,
  input  wire tmpg_pkg::cfg_t                  cfg,
  input  wire logic [tmpg_pkg::QCNT_W-1:0]     q_count,
  output logic                                 q_push,
  output tmpg_pkg::q_entry_t                   q_entry
);

  localparam int OFFS_W = 16;
  localparam int QSUM_W = tmpg_pkg::QCNT_W + 1;

  typedef struct packed {
    tmpg_pkg::cmd_t                    op;
    logic                              keep;
    logic [tmpg_pkg::TEXT_AW_MAX-1:0]  addr;
    logic [tmpg_pkg::COLOUR_W-1:0]     wdata;
    logic [OFFS_W-1:0]                 raw;
    logic [2:0]                        line;
    logic [2:0]                        bitsel;
    logic                              outside;
    logic                              cursor;
  } f1_t;

  f1_t               f1_r, f1_nxt;
  logic              f1_v_r, f1_v_nxt;
  logic [2:0]        blink_r, blink_nxt;

  tmpg_pkg::cmd_t    cmd;
  logic              accept;
  logic [6:0]        column;
  logic [6:0]        row;
  logic [OFFS_W-1:0] addr_ext;
  logic [OFFS_W-1:0] red1;
  logic [OFFS_W-1:0] red2;

  assign cmd      = tmpg_pkg::cmd_t'(in_command);
  assign column   = in_pixel_x[9:3];
  assign row      = in_pixel_y[9:3];
  assign addr_ext = OFFS_W'(in_address);
  assign in_ready = (QSUM_W'(q_count) + QSUM_W'(f1_v_r)) < QSUM_W'(tmpg_pkg::QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;

  always_comb begin
    f1_nxt.op      = cmd;
    f1_nxt.addr    = tmpg_pkg::TEXT_AW_MAX'(in_address);
    f1_nxt.wdata   = {4'b0000, in_write_data[7:0]};
    f1_nxt.raw     = OFFS_W'(column) + OFFS_W'(row) * OFFS_W'(LINE_STRIDE);
    f1_nxt.line    = in_pixel_y[2:0];
    f1_nxt.bitsel  = in_pixel_x[2:0];
    f1_nxt.outside = ({1'b0, column} >= 8'(SCREEN_COLUMNS)) ||
                     ({1'b0, row} >= 8'(SCREEN_ROWS));
    f1_nxt.cursor  = cfg.cursor_enable && !blink_r[2] &&
                     (16'(column) == cfg.cursor_column) &&
                     (16'(row) == cfg.cursor_row);
    case (cmd)
      tmpg_pkg::CMD_PIXEL:   f1_nxt.keep = 1'b1;
      tmpg_pkg::CMD_WR_CHAR,
      tmpg_pkg::CMD_WR_ATTR: f1_nxt.keep = addr_ext < OFFS_W'(TEXT_STORE_DEPTH);
      tmpg_pkg::CMD_WR_FONT: f1_nxt.keep = addr_ext < OFFS_W'(tmpg_pkg::FONT_DEPTH);
      tmpg_pkg::CMD_WR_PALETTE: begin
        f1_nxt.keep  = addr_ext < OFFS_W'(tmpg_pkg::PALETTE_DEPTH);
        // keep the upper nibbles of bytes 1..3 as red, green, blue
        f1_nxt.wdata = {in_write_data[15:12], in_write_data[23:20], in_write_data[31:28]};
      end
      default:               f1_nxt.keep = 1'b0;
    endcase
    f1_v_nxt  = accept;
    blink_nxt = blink_r + 3'((accept && (cmd == tmpg_pkg::CMD_FRAME)) ? 1 : 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r  <= 1'b0;
      blink_r <= '0;
    end else begin
      f1_v_r  <= f1_v_nxt;
      blink_r <= blink_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_r <= f1_nxt;
    end
  end

  // Wrap the cell offset into the text store (at most two wraps in range)
  always_comb begin
    red1 = (f1_r.raw >= OFFS_W'(2 * TEXT_STORE_DEPTH)) ?
           f1_r.raw - OFFS_W'(2 * TEXT_STORE_DEPTH) : f1_r.raw;
    red2 = (red1 >= OFFS_W'(TEXT_STORE_DEPTH)) ? red1 - OFFS_W'(TEXT_STORE_DEPTH) : red1;
  end

  always_comb begin
    q_push          = f1_v_r && f1_r.keep;
    q_entry.op      = f1_r.op;
    q_entry.wdata   = f1_r.wdata;
    q_entry.line    = f1_r.line;
    q_entry.bitsel  = f1_r.bitsel;
    q_entry.outside = f1_r.outside;
    q_entry.cursor  = f1_r.cursor;
    if (f1_r.op == tmpg_pkg::CMD_PIXEL) begin
      q_entry.addr = f1_r.outside ? '0 : red2[tmpg_pkg::TEXT_AW_MAX-1:0];
    end else begin
      q_entry.addr = f1_r.addr;
    end
  end

endmodule

`default_nettype wire

/* rtl/tmpg_back.sv */
// Back end: executes store writes and renders pixels through the text, font
// and palette stores. Depends on tmpg_pkg and tmpg_ram.
`default_nettype none

module tmpg_back #(
  parameter int TEXT_STORE_DEPTH = tmpg_pkg::TEXT_STORE_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire tmpg_pkg::cfg_t                    cfg,
  input  wire logic                              q_valid,
  input  wire tmpg_pkg::q_entry_t                q_entry,
  output logic                                   q_pop,
  input  wire logic [tmpg_pkg::OCNT_W-1:0]       o_count,
  output logic                                   o_push,
  output logic      [tmpg_pkg::COLOUR_W-1:0]     o_colour
);

  localparam int TEXT_AW = $clog2(TEXT_STORE_DEPTH);
  localparam int OSUM_W  = tmpg_pkg::OCNT_W + 1;

  typedef struct packed {
    tmpg_pkg::cmd_t                    op;
    logic [tmpg_pkg::PALETTE_AW-1:0]   addr;
    logic [tmpg_pkg::COLOUR_W-1:0]     wdata;
    logic [2:0]                        bitsel;
    logic [7:0]                        attr;
    logic                              outside;
  } s2_t;

  typedef struct packed {
    tmpg_pkg::cmd_t op;
    logic           outside;
  } s3_t;

  tmpg_pkg::q_entry_t s1_r;
  s2_t                s2_r, s2_nxt;
  s3_t                s3_r, s3_nxt;
  logic               s1_v_r, s2_v_r, s3_v_r;

  logic [1:0]                          inflight;
  logic [7:0]                          char_rdata, attr_rdata, font_rdata;
  logic [tmpg_pkg::COLOUR_W-1:0]       pal_rdata;
  logic [7:0]                          glyph;
  logic [tmpg_pkg::FONT_AW-1:0]        font_addr;
  logic [tmpg_pkg::PALETTE_AW-1:0]     pal_addr;
  logic                                font_bit;

  // Pop only when every transaction in flight still has a result slot
  assign inflight = 2'(s1_v_r) + 2'(s2_v_r) + 2'(s3_v_r);
  assign q_pop    = q_valid &&
                    ((OSUM_W'(inflight) + OSUM_W'(o_count)) < OSUM_W'(tmpg_pkg::OUT_DEPTH));

  // Stage 1: text stores
  tmpg_ram #(.WIDTH(8), .DEPTH(TEXT_STORE_DEPTH)) u_char_ram (
    .clk   (clk),
    .we    (q_pop && (q_entry.op == tmpg_pkg::CMD_WR_CHAR)),
    .addr  (q_entry.addr[TEXT_AW-1:0]),
    .wdata (q_entry.wdata[7:0]),
    .rdata (char_rdata)
  );

  tmpg_ram #(.WIDTH(8), .DEPTH(TEXT_STORE_DEPTH)) u_attr_ram (
    .clk   (clk),
    .we    (q_pop && (q_entry.op == tmpg_pkg::CMD_WR_ATTR)),
    .addr  (q_entry.addr[TEXT_AW-1:0]),
    .wdata (q_entry.wdata[7:0]),
    .rdata (attr_rdata)
  );

  // Stage 2: cursor override, font store
  always_comb begin
    glyph          = s1_r.cursor ? cfg.cursor_glyph : char_rdata;
    s2_nxt.op      = s1_r.op;
    s2_nxt.addr    = s1_r.addr[tmpg_pkg::PALETTE_AW-1:0];
    s2_nxt.wdata   = s1_r.wdata;
    s2_nxt.bitsel  = s1_r.bitsel;
    s2_nxt.attr    = s1_r.cursor ? cfg.cursor_attribute : attr_rdata;
    s2_nxt.outside = s1_r.outside;
    if (s1_r.op == tmpg_pkg::CMD_WR_FONT) begin
      font_addr = s1_r.addr[tmpg_pkg::FONT_AW-1:0];
    end else begin
      font_addr = {glyph, s1_r.line};
    end
  end

  tmpg_ram #(.WIDTH(8), .DEPTH(tmpg_pkg::FONT_DEPTH)) u_font_ram (
    .clk   (clk),
    .we    (s1_v_r && (s1_r.op == tmpg_pkg::CMD_WR_FONT)),
    .addr  (font_addr),
    .wdata (s1_r.wdata[7:0]),
    .rdata (font_rdata)
  );

  // Stage 3: pick the font bit MSB-first, palette lookup
  always_comb begin
    font_bit       = font_rdata[3'd7 - s2_r.bitsel];
    s3_nxt.op      = s2_r.op;
    s3_nxt.outside = s2_r.outside;
    if (s2_r.op == tmpg_pkg::CMD_WR_PALETTE) begin
      pal_addr = s2_r.addr;
    end else if (font_bit) begin
      pal_addr = {1'b0, s2_r.attr[7:4]};
    end else begin
      pal_addr = {1'b1, s2_r.attr[3:0]};
    end
  end

  tmpg_ram #(.WIDTH(tmpg_pkg::COLOUR_W), .DEPTH(tmpg_pkg::PALETTE_DEPTH)) u_pal_ram (
    .clk   (clk),
    .we    (s2_v_r && (s2_r.op == tmpg_pkg::CMD_WR_PALETTE)),
    .addr  (pal_addr),
    .wdata (s2_r.wdata),
    .rdata (pal_rdata)
  );

  // Stage 4: hand the colour to the result queue, black outside the text area
  assign o_push   = s3_v_r && (s3_r.op == tmpg_pkg::CMD_PIXEL);
  assign o_colour = s3_r.outside ? '0 : pal_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= q_pop;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= q_entry;
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
  end

endmodule

`default_nettype wire

/* rtl/text_mode_pixel_generator.sv */
// Text-mode pixel generator: one pixel colour per pixel transaction.
// Path: front register, command queue, back-end stages 1 to 3, result queue.
// Throughput: one transaction per cycle (single-port stores) unless the result queue fills.
// Reset clears the blink counter, cursor registers and all queues; the text,
// font and palette stores are not cleared and must be loaded before use.
// Depends on tmpg_pkg, tmpg_front, tmpg_fifo, tmpg_back and tmpg_ram.
`default_nettype none

module text_mode_pixel_generator #(
  parameter int LINE_STRIDE      = tmpg_pkg::LINE_STRIDE,
  parameter int SCREEN_COLUMNS   = tmpg_pkg::SCREEN_COLUMNS,
  parameter int SCREEN_ROWS      = tmpg_pkg::SCREEN_ROWS,
  parameter int TEXT_STORE_DEPTH = tmpg_pkg::TEXT_STORE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_command,
  input  wire logic [12:0] in_address,
  input  wire logic [31:0] in_write_data,
  input  wire logic [9:0]  in_pixel_x,
  input  wire logic [9:0]  in_pixel_y,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      out_pixel_colour,

  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  tmpg_pkg::cfg_t              cfg_r, cfg_nxt;
  tmpg_pkg::reg_t              reg_idx;
  logic                        cfg_wr;

  logic                        q_push, q_pop, q_valid;
  tmpg_pkg::q_entry_t          q_push_entry, q_head;
  logic [tmpg_pkg::Q_ENTRY_W-1:0] q_head_bits;
  logic [tmpg_pkg::QCNT_W-1:0] q_count;

  logic                        o_push;
  logic [tmpg_pkg::COLOUR_W-1:0] o_colour;
  logic [tmpg_pkg::OCNT_W-1:0] o_count;

  // Configuration registers
  assign reg_idx    = tmpg_pkg::reg_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        tmpg_pkg::REG_CURSOR_ENABLE:    cfg_nxt.cursor_enable    = cfg_pwdata[0];
        tmpg_pkg::REG_CURSOR_ROW:       cfg_nxt.cursor_row       = cfg_pwdata[15:0];
        tmpg_pkg::REG_CURSOR_COLUMN:    cfg_nxt.cursor_column    = cfg_pwdata[15:0];
        tmpg_pkg::REG_CURSOR_GLYPH:     cfg_nxt.cursor_glyph     = cfg_pwdata[7:0];
        tmpg_pkg::REG_CURSOR_ATTRIBUTE: cfg_nxt.cursor_attribute = cfg_pwdata[7:0];
        default:                        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tmpg_pkg::REG_CURSOR_ENABLE:    cfg_prdata = 32'(cfg_r.cursor_enable);
      tmpg_pkg::REG_CURSOR_ROW:       cfg_prdata = 32'(cfg_r.cursor_row);
      tmpg_pkg::REG_CURSOR_COLUMN:    cfg_prdata = 32'(cfg_r.cursor_column);
      tmpg_pkg::REG_CURSOR_GLYPH:     cfg_prdata = 32'(cfg_r.cursor_glyph);
      tmpg_pkg::REG_CURSOR_ATTRIBUTE: cfg_prdata = 32'(cfg_r.cursor_attribute);
      default:                        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tmpg_front #(
    .LINE_STRIDE      (LINE_STRIDE),
    .SCREEN_COLUMNS   (SCREEN_COLUMNS),
    .SCREEN_ROWS      (SCREEN_ROWS),
    .TEXT_STORE_DEPTH (TEXT_STORE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .cfg           (cfg_r),
    .q_count       (q_count),
    .q_push        (q_push),
    .q_entry       (q_push_entry)
  );

  tmpg_fifo #(
    .WIDTH (tmpg_pkg::Q_ENTRY_W),
    .DEPTH (tmpg_pkg::QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_entry),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_head_bits),
    .count     (q_count)
  );

  assign q_head = tmpg_pkg::q_entry_t'(q_head_bits);

  tmpg_back #(
    .TEXT_STORE_DEPTH (TEXT_STORE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_entry  (q_head),
    .q_pop    (q_pop),
    .o_count  (o_count),
    .o_push   (o_push),
    .o_colour (o_colour)
  );

  tmpg_fifo #(
    .WIDTH (tmpg_pkg::COLOUR_W),
    .DEPTH (tmpg_pkg::OUT_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (o_push),
    .push_data (o_colour),
    .pop       (out_ready),
    .valid     (out_valid),
    .pop_data  (out_pixel_colour),
    .count     (o_count)
  );

endmodule

`default_nettype wire
